### src/flash_command_interface_core_assert.svh
// Assertion macros for the flash command interface core.
// Both sample on clk and are off while arst_n is low.
`ifndef FLASH_COMMAND_INTERFACE_CORE_ASSERT_SVH
`define FLASH_COMMAND_INTERFACE_CORE_ASSERT_SVH

// Same-cycle implication.
`define FCI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FCI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/fci_pkg.sv
package fci_pkg;

	localparam int ARRAY_BYTES  = 16384;
	localparam int BLOCK_BYTES  = 1024;
	localparam int BUFFER_BYTES = 32;

	localparam int ADDR_W  = $clog2(ARRAY_BYTES);
	localparam int REM_W   = $clog2(BLOCK_BYTES + 1);
	localparam int FILL_W  = $clog2(BUFFER_BYTES + 1);
	localparam int BUF_IW  = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

	localparam int OP_W       = 2;
	localparam int FIELD_AW   = 14;
	localparam int DATA_W     = 8;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 16;
	localparam int CFG_IDX_W  = 2;

	typedef struct packed {
		logic              from_ram;
		logic [7:0]        rd_val;
		logic              ready;
		logic              we;
		logic              erase;
		logic [7:0]        mask;
		logic [ADDR_W-1:0] addr;
	} item_t;

endpackage

### src/flash_command_interface_core.sv
// Channel   Dir  Handshake             Payload
// s_        in   s_tvalid / s_tready   s_tdata: address, data; s_tuser: operation
// m_        out  m_tvalid / m_tready   m_tdata: read_data, ready_res
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One beat per cycle unless m_ stalls; results pass stage 1 and the output register.
// Program and erase ticks read the array memory in the accept cycle and write it back
// when stage 1 advances; a same-address read right behind a write is forwarded.
// After reset the array is filled with 0xFF, one byte a cycle, over all 16384 bytes;
// s_tready stays low until then, cfg writes are taken at any time.
// A stalled m_ side holds the result and stage 1, then drops s_tready.
module flash_command_interface_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [fci_pkg::S_TDATA_W-1:0]      s_tdata,   // address[13:0], data[21:14]
	input  logic [fci_pkg::OP_W-1:0]           s_tuser,   // operation[1:0]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [fci_pkg::M_TDATA_W-1:0]      m_tdata,   // read_data[7:0], ready_res[8]
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fci_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [7:0]                         cfg_data
);

	logic                          take;
	fci_pkg::item_t                item;
	logic                          ram_re;
	logic [fci_pkg::ADDR_W-1:0]    ram_raddr;
	logic                          ram_we;
	logic [fci_pkg::ADDR_W-1:0]    ram_waddr;
	logic [7:0]                    ram_wdata;
	logic [7:0]                    ram_rdata;

	assign cfg_ready = 1'b1;

	fci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.op        (s_tuser),
		.addr      (s_tdata[fci_pkg::ADDR_W-1:0]),
		.data      (s_tdata[fci_pkg::FIELD_AW +: fci_pkg::DATA_W]),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item)
	);

	fci_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.take      (take),
		.item      (item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	fci_ram #(
		.WIDTH (8),
		.DEPTH (fci_pkg::ARRAY_BYTES)
	) u_array (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### src/fci_ram.sv
module fci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/fci_ctrl.sv
module fci_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  logic [fci_pkg::OP_W-1:0]            op,
	input  logic [fci_pkg::ADDR_W-1:0]          addr,
	input  logic [fci_pkg::DATA_W-1:0]          data,
	input  logic                                cfg_write,
	input  logic [fci_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [7:0]                          cfg_data,
	output fci_pkg::item_t                      item
);

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [2:0] MODE_ARRAY       = 3'd0;
	localparam logic [2:0] MODE_IDENT       = 3'd1;
	localparam logic [2:0] MODE_STATUS      = 3'd2;
	localparam logic [2:0] MODE_ERASE_SETUP = 3'd3;
	localparam logic [2:0] MODE_PROG_SETUP  = 3'd4;
	localparam logic [2:0] MODE_BUF_COUNT   = 3'd5;
	localparam logic [2:0] MODE_BUF_DATA    = 3'd6;
	localparam logic [2:0] MODE_BUF_CONFIRM = 3'd7;

	localparam logic [1:0] BUSY_IDLE    = 2'd0;
	localparam logic [1:0] BUSY_PROGRAM = 2'd1;
	localparam logic [1:0] BUSY_ERASE   = 2'd2;
	localparam logic [1:0] BUSY_BUFFER  = 2'd3;

	localparam logic [7:0] CMD_READ_ARRAY = 8'hFF;
	localparam logic [7:0] CMD_IDENT      = 8'h90;
	localparam logic [7:0] CMD_STATUS     = 8'h70;
	localparam logic [7:0] CMD_CLEAR      = 8'h50;
	localparam logic [7:0] CMD_ERASE      = 8'h20;
	localparam logic [7:0] CMD_PROGRAM    = 8'h40;
	localparam logic [7:0] CMD_BUFFER     = 8'hE8;
	localparam logic [7:0] CMD_CONFIRM    = 8'hD0;

	localparam logic [1:0] CFG_VENDOR = 2'd0;
	localparam logic [1:0] CFG_DEVICE = 2'd1;
	localparam logic [1:0] CFG_TICKS  = 2'd2;

	localparam logic [7:0] ID_VENDOR_ADDR = 8'd0;
	localparam logic [7:0] ID_DEVICE_ADDR = 8'd2;

	localparam logic [fci_pkg::FILL_W-1:0] BUF_FULL = fci_pkg::FILL_W'(fci_pkg::BUFFER_BYTES);
	localparam logic [fci_pkg::ADDR_W-1:0] BLOCK_MASK =
		fci_pkg::ADDR_W'(fci_pkg::BLOCK_BYTES - 1);
	localparam logic [fci_pkg::ADDR_W-1:0] ADDR_LAST =
		fci_pkg::ADDR_W'(fci_pkg::ARRAY_BYTES - 1);

	logic [2:0]                   mode_q, mode_d;
	logic [1:0]                   err_q, err_d;
	logic [1:0]                   busy_q, busy_d;
	logic [7:0]                   tick_q, tick_d;
	logic [fci_pkg::ADDR_W-1:0]   waddr_q, waddr_d;
	logic [fci_pkg::REM_W-1:0]    rem_q, rem_d, rem_m;
	logic [fci_pkg::FILL_W-1:0]   fill_q, fill_d, fill_inc;
	logic [fci_pkg::FILL_W-1:0]   len_q, len_d;
	logic [7:0]                   buf_q [fci_pkg::BUFFER_BYTES];
	logic [7:0]                   vendor_q, device_q, pticks_q;

	logic                         buf_wr;
	logic [fci_pkg::BUF_IW-1:0]   buf_idx;
	logic                         idle;
	logic                         adv;
	logic [7:0]                   status;
	logic [7:0]                   need;
	logic [7:0]                   tc;

	assign idle     = (busy_q == BUSY_IDLE);
	assign status   = {idle, 1'b0, err_q, 4'b0000};
	assign need     = (pticks_q == 8'd0) ? 8'd1 : pticks_q;
	assign tc       = tick_q + 8'd1;
	assign rem_m    = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
	assign fill_inc = fill_q + 1'b1;

	always_comb begin
		mode_d  = mode_q;
		err_d   = err_q;
		busy_d  = busy_q;
		tick_d  = tick_q;
		waddr_d = waddr_q;
		rem_d   = rem_q;
		fill_d  = fill_q;
		len_d   = len_q;
		buf_wr  = 1'b0;
		buf_idx = fill_q[fci_pkg::BUF_IW-1:0];
		adv     = 1'b0;

		item.from_ram = 1'b0;
		item.rd_val   = 8'd0;
		item.we       = 1'b0;
		item.erase    = 1'b0;
		item.mask     = buf_q[fill_q[fci_pkg::BUF_IW-1:0]];
		item.addr     = addr;

		case (op)
			OP_READ: begin
				if (!idle) begin
					item.rd_val = status;
				end else begin
					case (mode_q)
						MODE_ARRAY: item.from_ram = 1'b1;
						MODE_IDENT: begin
							if (addr == fci_pkg::ADDR_W'(ID_VENDOR_ADDR)) begin
								item.rd_val = vendor_q;
							end else if (addr == fci_pkg::ADDR_W'(ID_DEVICE_ADDR)) begin
								item.rd_val = device_q;
							end
						end
						default: item.rd_val = status;
					endcase
				end
			end
			OP_WRITE: begin
				if (idle) begin
					case (mode_q)
						MODE_ERASE_SETUP: begin
							if (data == CMD_CONFIRM) begin
								busy_d  = BUSY_ERASE;
								waddr_d = addr & ~BLOCK_MASK;
								rem_d   = fci_pkg::REM_W'(fci_pkg::BLOCK_BYTES);
							end else begin
								err_d = 2'b11;
							end
							mode_d = MODE_STATUS;
						end
						MODE_PROG_SETUP: begin
							buf_wr  = 1'b1;
							buf_idx = '0;
							fill_d  = '0;
							len_d   = fci_pkg::FILL_W'(1);
							waddr_d = addr;
							rem_d   = fci_pkg::REM_W'(1);
							tick_d  = 8'd0;
							busy_d  = BUSY_PROGRAM;
							mode_d  = MODE_STATUS;
						end
						MODE_BUF_COUNT: begin
							if ({1'b0, data} >= 9'(fci_pkg::BUFFER_BYTES)) begin
								len_d = BUF_FULL;
							end else begin
								len_d = fci_pkg::FILL_W'(data) + 1'b1;
							end
							fill_d = '0;
							mode_d = MODE_BUF_DATA;
						end
						MODE_BUF_DATA: begin
							buf_wr = (fill_q < BUF_FULL);
							fill_d = fill_inc;
							if (fill_inc >= len_q) begin
								mode_d = MODE_BUF_CONFIRM;
							end
						end
						MODE_BUF_CONFIRM: begin
							if (data == CMD_CONFIRM) begin
								busy_d = BUSY_BUFFER;
								rem_d  = fci_pkg::REM_W'(len_q);
								fill_d = '0;
								tick_d = 8'd0;
							end else begin
								err_d = 2'b11;
							end
							mode_d = MODE_STATUS;
						end
						default: begin
							case (data)
								CMD_READ_ARRAY: mode_d = MODE_ARRAY;
								CMD_IDENT:      mode_d = MODE_IDENT;
								CMD_STATUS:     mode_d = MODE_STATUS;
								CMD_CLEAR:      err_d  = 2'b00;
								CMD_ERASE:      mode_d = MODE_ERASE_SETUP;
								CMD_PROGRAM:    mode_d = MODE_PROG_SETUP;
								CMD_BUFFER: begin
									waddr_d = addr;
									mode_d  = MODE_BUF_COUNT;
								end
								default: ;
							endcase
						end
					endcase
				end
			end
			OP_TICK: begin
				item.addr = waddr_q;
				if (!idle) begin
					if (busy_q == BUSY_ERASE) begin
						item.we    = 1'b1;
						item.erase = 1'b1;
						adv        = 1'b1;
					end else if (tc < need) begin
						tick_d = tc;
					end else begin
						tick_d  = 8'd0;
						item.we = (fill_q < BUF_FULL);
						fill_d  = fill_inc;
						adv     = 1'b1;
					end
				end
				if (adv) begin
					waddr_d = (waddr_q == ADDR_LAST) ? '0 : waddr_q + 1'b1;
					rem_d   = rem_m;
					if (rem_m == '0) begin
						busy_d = BUSY_IDLE;
					end
				end
			end
			default: ;
		endcase

		item.ready = (busy_d == BUSY_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ARRAY;
			err_q   <= 2'b00;
			busy_q  <= BUSY_IDLE;
			tick_q  <= 8'd0;
			waddr_q <= '0;
			rem_q   <= '0;
			fill_q  <= '0;
			len_q   <= '0;
		end else if (take) begin
			mode_q  <= mode_d;
			err_q   <= err_d;
			busy_q  <= busy_d;
			tick_q  <= tick_d;
			waddr_q <= waddr_d;
			rem_q   <= rem_d;
			fill_q  <= fill_d;
			len_q   <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && buf_wr) begin
			buf_q[buf_idx] <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_q <= 8'd137;
			device_q <= 8'd24;
			pticks_q <= 8'd8;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_VENDOR: vendor_q <= cfg_data;
				CFG_DEVICE: device_q <= cfg_data;
				CFG_TICKS:  pticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### src/fci_pipe.sv
`include "flash_command_interface_core_assert.svh"

module fci_pipe (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	output logic                             take,
	input  fci_pkg::item_t                   item,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fci_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                             ram_re,
	output logic [fci_pkg::ADDR_W-1:0]       ram_raddr,
	output logic                             ram_we,
	output logic [fci_pkg::ADDR_W-1:0]       ram_waddr,
	output logic [7:0]                       ram_wdata,
	input  logic [7:0]                       ram_rdata
);

	localparam logic [fci_pkg::ADDR_W-1:0] ADDR_LAST =
		fci_pkg::ADDR_W'(fci_pkg::ARRAY_BYTES - 1);

	logic                         clr_busy_q;
	logic [fci_pkg::ADDR_W-1:0]   clr_addr_q;
	logic                         valid_s1;
	fci_pkg::item_t               item_s1;
	logic                         fwd_q;
	logic [7:0]                   fwd_data_q;
	logic                         out_valid_q;
	logic [7:0]                   out_rd_q;
	logic                         out_ready_q;

	logic                         adv_s1;
	logic                         s1_we;
	logic                         fwd_hit;
	logic [7:0]                   merged;
	logic [7:0]                   s1_wdata;

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !clr_busy_q && (!valid_s1 || adv_s1);
	assign take     = s_tvalid && s_tready;

	assign merged   = fwd_q ? fwd_data_q : ram_rdata;
	assign s1_wdata = item_s1.erase ? 8'hFF : (merged & item_s1.mask);
	assign s1_we    = adv_s1 && item_s1.we;
	assign fwd_hit  = s1_we && (item_s1.addr == item.addr);

	assign ram_re    = take;
	assign ram_raddr = item.addr;
	assign ram_we    = clr_busy_q || s1_we;
	assign ram_waddr = clr_busy_q ? clr_addr_q : item_s1.addr;
	assign ram_wdata = clr_busy_q ? 8'hFF : s1_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1    <= item;
			fwd_q      <= fwd_hit;
			fwd_data_q <= s1_wdata;
		end
		if (adv_s1) begin
			out_rd_q    <= item_s1.from_ram ? merged : item_s1.rd_val;
			out_ready_q <= item_s1.ready;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_ready_q, out_rd_q};

	`FCI_ASSERT_NOW(a_clr_no_item, clr_busy_q, !valid_s1 && !take, "beat taken during array clear")
	`FCI_ASSERT_NOW(a_s1_drains, take && valid_s1, adv_s1, "stage 1 overwritten while stalled")
	`FCI_ASSERT_NEXT(a_fwd_set, take && fwd_hit, fwd_q, "write to read address not forwarded")
	`FCI_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s1, valid_s1 && $stable(item_s1), "stage 1 moved")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

	typedef enum logic [1:0] {OP_READ, OP_WRITE, OP_TICK, OP_NONE} fop_e;
	typedef enum logic [1:0] {REG_VENDOR, REG_DEVICE, REG_TICKS, REG_SPARE} reg_e;
	typedef enum logic [2:0] {
		MODE_ARRAY, MODE_IDENT, MODE_STATUS, MODE_ERASE_SETUP,
		MODE_PROG_SETUP, MODE_BUF_COUNT, MODE_BUF_DATA, MODE_BUF_CONFIRM
	} mode_e;
	typedef enum logic [1:0] {BUSY_IDLE, BUSY_PROGRAM, BUSY_ERASE, BUSY_BUFFER} busy_e;

	typedef struct packed {
		logic [7:0] read_data;
		logic       ready_res;
	} flash_result_t;

	localparam logic [7:0] CMD_READ_ARRAY  = 8'hFF;
	localparam logic [7:0] CMD_IDENT       = 8'h90;
	localparam logic [7:0] CMD_STATUS      = 8'h70;
	localparam logic [7:0] CMD_CLEAR       = 8'h50;
	localparam logic [7:0] CMD_ERASE       = 8'h20;
	localparam logic [7:0] CMD_CONFIRM     = 8'hD0;
	localparam logic [7:0] CMD_PROGRAM     = 8'h40;
	localparam logic [7:0] CMD_BUF_PROGRAM = 8'hE8;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [fci_pkg::S_TDATA_W-1:0]   s_tdata = '0;
	logic [fci_pkg::OP_W-1:0]        s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [fci_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [fci_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [7:0]                      cfg_data = '0;

	logic [7:0]  mem_img [fci_pkg::ARRAY_BYTES];
	logic [7:0]  wbuf [fci_pkg::BUFFER_BYTES];
	mode_e       mode = MODE_ARRAY;
	busy_e       busy = BUSY_IDLE;
	logic [1:0]  err = 2'b00;
	logic [7:0]  tick_cnt = '0;
	logic [13:0] work_addr = '0;
	logic [10:0] work_left = '0;
	logic [5:0]  fill = '0;
	logic [5:0]  blen = '0;
	logic [7:0]  vendor = 8'd137;
	logic [7:0]  device = 8'd24;
	logic [7:0]  ticks_per_byte = 8'd8;

	flash_result_t expected_q[$];
	flash_result_t head;
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_cycles = 0;
	logic [13:0] hot_addr = '0;

	flash_command_interface_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] status_byte();
		return {busy == BUSY_IDLE, 1'b0, err[1], err[0], 4'h0};
	endfunction

	function automatic flash_result_t flash_step(fop_e op, logic [13:0] a, logic [7:0] d);
		flash_result_t r;
		logic [7:0] need;
		bit step_on;
		r.read_data = '0;
		step_on = 1'b0;
		case (op)
		OP_READ: begin
			if (busy != BUSY_IDLE) r.read_data = status_byte();
			else if (mode == MODE_ARRAY) r.read_data = mem_img[a];
			else if (mode == MODE_IDENT)
				r.read_data = (a == 0) ? vendor : (a == 2) ? device : 8'h00;
			else r.read_data = status_byte();
		end
		OP_WRITE: if (busy == BUSY_IDLE) begin
			case (mode)
			MODE_ERASE_SETUP: begin
				if (d == CMD_CONFIRM) begin
					busy = BUSY_ERASE;
					work_addr = 14'(a - (a % fci_pkg::BLOCK_BYTES));
					work_left = 11'(fci_pkg::BLOCK_BYTES);
				end else begin
					err = 2'b11;
				end
				mode = MODE_STATUS;
			end
			MODE_PROG_SETUP: begin
				wbuf[0] = d;
				fill = '0;
				blen = 6'd1;
				work_addr = a;
				work_left = 11'd1;
				tick_cnt = '0;
				busy = BUSY_PROGRAM;
				mode = MODE_STATUS;
			end
			MODE_BUF_COUNT: begin
				blen = (d >= fci_pkg::BUFFER_BYTES) ? 6'(fci_pkg::BUFFER_BYTES) : 6'(d + 1);
				fill = '0;
				mode = MODE_BUF_DATA;
			end
			MODE_BUF_DATA: begin
				if (fill < fci_pkg::BUFFER_BYTES) wbuf[fill[4:0]] = d;
				fill = fill + 6'd1;
				if (fill >= blen) mode = MODE_BUF_CONFIRM;
			end
			MODE_BUF_CONFIRM: begin
				if (d == CMD_CONFIRM) begin
					busy = BUSY_BUFFER;
					work_left = 11'(blen);
					fill = '0;
					tick_cnt = '0;
				end else begin
					err = 2'b11;
				end
				mode = MODE_STATUS;
			end
			default: begin
				case (d)
				CMD_READ_ARRAY: mode = MODE_ARRAY;
				CMD_IDENT: mode = MODE_IDENT;
				CMD_STATUS: mode = MODE_STATUS;
				CMD_CLEAR: err = 2'b00;
				CMD_ERASE: mode = MODE_ERASE_SETUP;
				CMD_PROGRAM: mode = MODE_PROG_SETUP;
				CMD_BUF_PROGRAM: begin
					work_addr = a;
					mode = MODE_BUF_COUNT;
				end
				default: ;
				endcase
			end
			endcase
		end
		OP_TICK: if (busy != BUSY_IDLE) begin
			if (busy == BUSY_ERASE) begin
				mem_img[work_addr] = 8'hFF;
				step_on = 1'b1;
			end else begin
				need = (ticks_per_byte == 0) ? 8'd1 : ticks_per_byte;
				tick_cnt = tick_cnt + 8'd1;
				if (tick_cnt >= need) begin
					tick_cnt = '0;
					if (fill < fci_pkg::BUFFER_BYTES)
						mem_img[work_addr] = mem_img[work_addr] & wbuf[fill[4:0]];
					fill = fill + 6'd1;
					step_on = 1'b1;
				end
			end
			if (step_on) begin
				work_addr = work_addr + 14'd1;
				if (work_left > 0) work_left = work_left - 11'd1;
				if (work_left == 0) busy = BUSY_IDLE;
			end
		end
		default: ;
		endcase
		r.ready_res = (busy == BUSY_IDLE);
		return r;
	endfunction

	task automatic report_miss(input string what, input int got, input int exp_v);
		$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_v);
		mismatches++;
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report_miss("unexpected beat", m_tdata, 0);
			end else begin
				head = expected_q.pop_front();
				if (m_tdata[7:0] !== head.read_data)
					report_miss("read_data", m_tdata[7:0], head.read_data);
				if (m_tdata[8] !== head.ready_res)
					report_miss("ready_res", m_tdata[8], head.ready_res);
			end
		end
	end

	task automatic send_beat(input fop_e op, input logic [13:0] a, input logic [7:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, d, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_q.push_back(flash_step(op, a, d));
		@(negedge clk);
	endtask

	task automatic cmd(input logic [7:0] d, input logic [13:0] a);
		send_beat(OP_WRITE, a, d);
	endtask

	task automatic rd(input logic [13:0] a);
		send_beat(OP_READ, a, 8'($urandom));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_e idx, input logic [7:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
		REG_VENDOR: vendor = v;
		REG_DEVICE: device = v;
		REG_TICKS: ticks_per_byte = v;
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// tick until program or erase finishes, mixing in noise; with may_leave set, sometimes returns at once
	task automatic run_to_idle(input bit may_leave);
		if (may_leave && $urandom_range(19) == 0) return;
		while (busy != BUSY_IDLE) begin
			if ($urandom_range(9) == 0)
				send_beat(fop_e'($urandom_range(3)), 14'($urandom), 8'($urandom));
			else
				send_beat(OP_TICK, 14'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_reset_defaults();
		rd(14'd0);
		rd(14'd16383);
		cmd(CMD_IDENT, 14'd0);
		rd(14'd0);
		rd(14'd2);
		rd(14'd1);
		cmd(CMD_STATUS, 14'd0);
		rd(14'd77);
		send_beat(OP_NONE, 14'h3FFF, 8'hFF);
		cmd(CMD_PROGRAM, 14'd0);
		cmd(8'h00, 14'd16383);
		rd(14'd16383);
		cmd(CMD_READ_ARRAY, 14'd0);
		repeat (8) send_beat(OP_TICK, 14'd0, 8'h00);
		cmd(CMD_READ_ARRAY, 14'd0);
		rd(14'd16383);
	endtask

	task automatic test_register_extremes();
		write_reg(REG_VENDOR, 8'h00);
		write_reg(REG_DEVICE, 8'hFF);
		write_reg(REG_TICKS, 8'h00);
		write_reg(REG_SPARE, 8'($urandom));
		cmd(CMD_IDENT, 14'd0);
		rd(14'd0);
		rd(14'd2);
		cmd(CMD_PROGRAM, 14'd0);
		cmd(8'h5A, 14'd100);
		run_to_idle(1'b0);
		write_reg(REG_VENDOR, 8'hFF);
		write_reg(REG_DEVICE, 8'h00);
		write_reg(REG_TICKS, 8'hFF);
		cmd(CMD_IDENT, 14'd0);
		rd(14'd0);
		rd(14'd2);
		rd(14'd3);
		cmd(CMD_PROGRAM, 14'd0);
		cmd(8'hA5, 14'd101);
		run_to_idle(1'b0);
		cmd(CMD_READ_ARRAY, 14'd0);
		rd(14'd100);
		rd(14'd101);
		write_reg(REG_TICKS, 8'd1);
	endtask

	task automatic test_command_errors();
		cmd(CMD_CONFIRM, 14'd5);
		rd(14'd5);
		cmd(8'h3C, 14'd5);
		cmd(CMD_ERASE, 14'd0);
		cmd(8'h55, 14'd0);
		rd(14'd0);
		cmd(CMD_CLEAR, 14'd0);
		rd(14'd0);
		cmd(CMD_BUF_PROGRAM, 14'd200);
		cmd(8'd1, 14'd0);
		cmd(8'h11, 14'd9);
		cmd(8'h22, 14'd9);
		cmd(8'h00, 14'd0);
		rd(14'd200);
		cmd(CMD_CLEAR, 14'd0);
		cmd(CMD_READ_ARRAY, 14'd0);
		rd(14'd200);
	endtask

	task automatic test_buffer_wrap();
		cmd(CMD_BUF_PROGRAM, 14'd16380);
		cmd(8'hFF, 14'd0);
		repeat (fci_pkg::BUFFER_BYTES) cmd(8'($urandom), 14'($urandom));
		cmd(CMD_CONFIRM, 14'd0);
		run_to_idle(1'b0);
		cmd(CMD_READ_ARRAY, 14'd0);
		rd(14'd16380);
		rd(14'd16383);
		rd(14'd0);
		rd(14'd27);
		rd(14'd28);
		cmd(CMD_BUF_PROGRAM, 14'd500);
		cmd(8'd0, 14'd0);
		cmd(8'h0F, 14'd0);
		cmd(CMD_CONFIRM, 14'd0);
		run_to_idle(1'b0);
		cmd(CMD_READ_ARRAY, 14'd0);
		rd(14'd500);
	endtask

	task automatic test_block_erase();
		cmd(CMD_ERASE, 14'd3);
		cmd(CMD_CONFIRM, 14'd15872);
		rd(14'd15360);
		run_to_idle(1'b0);
		cmd(CMD_READ_ARRAY, 14'd0);
		rd(14'd15360);
		rd(14'd16383);
		rd(14'd0);
		rd(14'd15359);
	endtask

	task automatic test_backpressure();
		int k;
		drain();
		@(posedge clk);
		hold_cycles = 300;
		@(negedge clk);
		for (k = 0; k < 40; k++) rd(14'(k * 411));
		drain();
	endtask

	task automatic test_random_traffic(input int n_seq, input logic [7:0] ticks);
		int kind;
		int len;
		int n;
		logic [13:0] base;
		write_reg(REG_VENDOR, 8'($urandom));
		write_reg(REG_DEVICE, 8'($urandom));
		write_reg(REG_TICKS, ticks);
		repeat (n_seq) begin
			kind = $urandom_range(99);
			base = ($urandom_range(3) == 0) ? 14'(hot_addr + $urandom_range(40)) : 14'($urandom);
			if (kind < 10) begin
				repeat ($urandom_range(1, 3))
					send_beat(fop_e'($urandom_range(3)), 14'($urandom), 8'($urandom));
			end else if (kind < 20) begin
				cmd(CMD_READ_ARRAY, 14'($urandom));
				repeat ($urandom_range(1, 4)) rd(14'(hot_addr + $urandom_range(40)));
			end else if (kind < 27) begin
				cmd(CMD_IDENT, 14'($urandom));
				case ($urandom_range(2))
				0: rd(14'd0);
				1: rd(14'd2);
				default: rd(14'($urandom));
				endcase
			end else if (kind < 33) begin
				cmd(($urandom_range(1) == 0) ? CMD_STATUS : CMD_CLEAR, 14'($urandom));
				rd(14'($urandom));
			end else if (kind < 53) begin
				cmd(CMD_PROGRAM, 14'($urandom));
				cmd(8'($urandom), base);
				hot_addr = base;
				run_to_idle(1'b1);
				cmd(CMD_READ_ARRAY, 14'($urandom));
				rd(base);
			end else if (kind < 78) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(7);
				n = (len >= fci_pkg::BUFFER_BYTES) ? fci_pkg::BUFFER_BYTES : len + 1;
				cmd(CMD_BUF_PROGRAM, base);
				cmd(8'(len), 14'($urandom));
				repeat (n) cmd(8'($urandom), 14'($urandom));
				cmd(($urandom_range(9) == 0) ? 8'($urandom) : CMD_CONFIRM, 14'($urandom));
				hot_addr = base;
				run_to_idle(1'b1);
				cmd(CMD_READ_ARRAY, 14'($urandom));
				repeat ($urandom_range(1, 3)) rd(14'(base + $urandom_range(n)));
			end else if (kind < 83) begin
				cmd(CMD_ERASE, 14'($urandom));
				cmd(8'($urandom_range(8'hCF)), base);
				hot_addr = base;
				run_to_idle(1'b1);
				cmd(CMD_READ_ARRAY, 14'($urandom));
				rd(base);
				rd(14'($urandom));
			end else begin
				case ($urandom_range(3))
				0: cmd(CMD_ERASE, base);
				1: cmd(CMD_PROGRAM, base);
				2: cmd(CMD_BUF_PROGRAM, base);
				default: cmd(8'($urandom), base);
				endcase
				rd(14'($urandom));
				cmd(8'($urandom), 14'($urandom));
			end
		end
	endtask

	initial begin
		foreach (mem_img[i]) mem_img[i] = 8'hFF;
		foreach (wbuf[i]) wbuf[i] = 8'h00;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 20;
		recv_idle_pct = 80;
		test_reset_defaults();
		test_register_extremes();
		test_command_errors();
		test_buffer_wrap();
		test_block_erase();
		test_backpressure();
		test_random_traffic(12, 8'($urandom_range(1, 3)));
		send_idle_pct = 80;
		recv_idle_pct = 20;
		test_random_traffic(12, 8'd2);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(12, 8'd1);
		drain();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
